FILE: src/mlptw_pkg.sv
package mlptw_pkg;

    // Table geometry
    localparam int LEVELS     = 5;
    localparam int INDEX_BITS = 9;
    localparam int FRAMES     = 64;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int VPN_W      = 45;
    localparam int PPN_W      = 52;
    localparam int ROOT_W     = 6;
    localparam int NF_W       = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Derived sizes
    localparam int ENTRY_W   = PPN_W + 1;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int MEM_DEPTH = FRAMES << INDEX_BITS;
    localparam int ADDR_W    = FRAME_W + INDEX_BITS;
    localparam int LVL_W     = $clog2(LEVELS);

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_QUERY = 2'd0,
        ACT_MAP   = 2'd1,
        ACT_UNMAP = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic rd;
        logic eval;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic skip;
        logic walk_end;
        logic out_free;
    } t_status;

endpackage

FILE: src/mlptw_ctrl.sv
module mlptw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mlptw_pkg::t_status i_status,
    output mlptw_pkg::t_cmd    o_cmd
);

    mlptw_pkg::t_state r_state;
    mlptw_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlptw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlptw_pkg::S_CLEAR: begin
                if (i_status.clr_last) n_state = mlptw_pkg::S_IDLE;
            end
            mlptw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.skip ? mlptw_pkg::S_DONE : mlptw_pkg::S_READ;
                end
            end
            mlptw_pkg::S_READ: begin
                n_state = mlptw_pkg::S_EVAL;
            end
            mlptw_pkg::S_EVAL: begin
                n_state = i_status.walk_end ? mlptw_pkg::S_DONE : mlptw_pkg::S_READ;
            end
            mlptw_pkg::S_DONE: begin
                if (i_status.out_free) n_state = mlptw_pkg::S_IDLE;
            end
            default: begin
                n_state = mlptw_pkg::S_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            mlptw_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            mlptw_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            mlptw_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
            end
            mlptw_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            mlptw_pkg::S_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/mlptw_dp.sv
module mlptw_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mlptw_pkg::t_cmd                     i_cmd,
    output mlptw_pkg::t_status                  o_status,
    input  logic [mlptw_pkg::ACTION_W-1:0]      i_action,
    input  logic [mlptw_pkg::VPN_W-1:0]         i_vpn,
    input  logic [mlptw_pkg::PPN_W-1:0]         i_ppn,
    input  logic                                i_cfg_valid,
    input  logic [mlptw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlptw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_mapped,
    output logic [mlptw_pkg::PPN_W-1:0]         o_ppn_out,
    output logic                                o_out_of_frames
);

    // Frame memory
    logic [mlptw_pkg::ENTRY_W-1:0] r_mem [mlptw_pkg::MEM_DEPTH];
    logic [mlptw_pkg::ENTRY_W-1:0] r_rdata;

    // Configuration and allocator
    logic [mlptw_pkg::ROOT_W-1:0] r_root;
    logic [mlptw_pkg::NF_W-1:0]   r_next_free;
    logic [mlptw_pkg::ADDR_W-1:0] r_clr_cnt;

    // Walk state
    mlptw_pkg::t_action               r_action;
    logic [mlptw_pkg::VPN_W-1:0]      r_vpn;
    logic [mlptw_pkg::PPN_W-1:0]      r_ppn;
    logic [mlptw_pkg::LVL_W-1:0]      r_lvl;
    logic [mlptw_pkg::FRAME_W-1:0]    r_frame;
    logic                             r_res_mapped;
    logic [mlptw_pkg::PPN_W-1:0]      r_res_ppn;
    logic                             r_res_oof;

    // Output register
    logic                             r_out_valid;
    logic                             r_out_mapped;
    logic [mlptw_pkg::PPN_W-1:0]      r_out_ppn;
    logic                             r_out_oof;

    logic [mlptw_pkg::INDEX_BITS-1:0] idx;
    logic [mlptw_pkg::ADDR_W-1:0]     addr;
    logic                             points;
    logic                             mem_we;
    logic [mlptw_pkg::ENTRY_W-1:0]    mem_wdata;
    logic                             walk_end;
    logic                             end_mapped;
    logic [mlptw_pkg::PPN_W-1:0]      end_ppn;
    logic                             end_oof;
    logic                             alloc;
    logic [mlptw_pkg::FRAME_W-1:0]    step_frame;

    // Address: sweep counter while clearing, else the current slot
    assign idx    = mlptw_pkg::INDEX_BITS'(r_vpn >> (mlptw_pkg::INDEX_BITS * 32'(r_lvl)));
    assign addr   = i_cmd.clr_step ? r_clr_cnt : {r_frame, idx};
    assign points = r_rdata[0]
                    && ((r_rdata >> 1) < mlptw_pkg::ENTRY_W'(mlptw_pkg::FRAMES));

    // Evaluate the fetched entry
    always_comb begin
        mem_we     = 1'b0;
        mem_wdata  = '0;
        walk_end   = 1'b0;
        end_mapped = 1'b0;
        end_ppn    = '0;
        end_oof    = 1'b0;
        alloc      = 1'b0;
        step_frame = mlptw_pkg::FRAME_W'(r_rdata >> 1);
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.eval) begin
            if (r_lvl == '0) begin
                walk_end = 1'b1;
                unique case (r_action)
                    mlptw_pkg::ACT_QUERY: begin
                        if (r_rdata[0]) begin
                            end_mapped = 1'b1;
                            end_ppn    = r_rdata[mlptw_pkg::ENTRY_W-1:1];
                        end
                    end
                    mlptw_pkg::ACT_MAP: begin
                        mem_we     = 1'b1;
                        mem_wdata  = {r_ppn, 1'b1};
                        end_mapped = 1'b1;
                    end
                    mlptw_pkg::ACT_UNMAP: begin
                        mem_we     = 1'b1;
                        end_mapped = 1'b1;
                    end
                    default: begin
                        end_mapped = 1'b0;
                    end
                endcase
            end else if (!points) begin
                if (r_action != mlptw_pkg::ACT_MAP) begin
                    walk_end = 1'b1;
                end else if (32'(r_next_free) >= mlptw_pkg::FRAMES) begin
                    walk_end = 1'b1;
                    end_oof  = 1'b1;
                end else begin
                    alloc      = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = {mlptw_pkg::PPN_W'(r_next_free), 1'b1};
                    step_frame = mlptw_pkg::FRAME_W'(r_next_free);
                end
            end
        end
    end

    // Memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[addr] <= mem_wdata;
        if (i_cmd.rd) r_rdata <= r_mem[addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_next_free <= mlptw_pkg::NF_W'(1);
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_cnt <= r_clr_cnt + mlptw_pkg::ADDR_W'(1);
            if (i_cfg_valid && i_cfg_index == mlptw_pkg::CFG_ROOT_FRAME) begin
                r_root <= i_cfg_data[mlptw_pkg::ROOT_W-1:0];
            end
            if (i_cfg_valid && i_cfg_index == mlptw_pkg::CFG_FIRST_FREE) begin
                r_next_free <= i_cfg_data[mlptw_pkg::NF_W-1:0];
            end else if (alloc) begin
                r_next_free <= r_next_free + mlptw_pkg::NF_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers: load on accept, advance one level per evaluation, record the result at walk end
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action     <= mlptw_pkg::t_action'(i_action);
            r_vpn        <= i_vpn;
            r_ppn        <= i_ppn;
            r_lvl        <= mlptw_pkg::LVL_W'(mlptw_pkg::LEVELS - 1);
            r_frame      <= mlptw_pkg::FRAME_W'(r_root);
            r_res_mapped <= 1'b0;
            r_res_ppn    <= '0;
            r_res_oof    <= 1'b0;
        end else if (i_cmd.eval) begin
            if (walk_end) begin
                r_res_mapped <= end_mapped;
                r_res_ppn    <= end_ppn;
                r_res_oof    <= end_oof;
            end else begin
                r_lvl   <= r_lvl - mlptw_pkg::LVL_W'(1);
                r_frame <= step_frame;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_mapped <= r_res_mapped;
            r_out_ppn    <= r_res_ppn;
            r_out_oof    <= r_res_oof;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mapped        = r_out_mapped;
    assign o_ppn_out       = r_out_ppn;
    assign o_out_of_frames = r_out_oof;

    assign o_status.clr_last = (r_clr_cnt == mlptw_pkg::ADDR_W'(mlptw_pkg::MEM_DEPTH - 1));
    assign o_status.skip     = (i_action == mlptw_pkg::ACT_NONE)
                               || (32'(r_root) >= mlptw_pkg::FRAMES);
    assign o_status.walk_end = walk_end;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    a_leaf_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_lvl == '0) |-> walk_end)
        else $error("walk did not end at the leaf level");

    a_lvl_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && !walk_end) |=> (r_lvl == $past(r_lvl) - mlptw_pkg::LVL_W'(1)))
        else $error("level did not advance after an intermediate entry");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an item not yet taken");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_mapped && r_out_oof))
        else $error("result both mapped and out of frames");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |-> (32'(r_next_free) < mlptw_pkg::FRAMES))
        else $error("frame allocated past the end of the memory");

endmodule

FILE: src/multi_level_page_table_walker_top.sv
// Walk: each level visited is read in S_READ and then evaluated in S_EVAL, and the result
// is loaded in S_DONE (a full walk visits all five levels, an unused action goes straight
// from S_IDLE to S_DONE); the next item is taken back in S_IDLE. A result not taken holds
// the walker until it is. No new item is taken before the current one is done; each level's
// entry is read from the single-port frame memory in S_READ and evaluated (and written) in S_EVAL.
// Reset: synchronous; a clearing pass zeroes all 32768 entries of the frame memory, with
// no item taken meanwhile; configuration writes are taken throughout.
module multi_level_page_table_walker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mlptw_pkg::ACTION_W-1:0]      i_action,
    input  logic [mlptw_pkg::VPN_W-1:0]         i_vpn,
    input  logic [mlptw_pkg::PPN_W-1:0]         i_ppn,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_mapped,
    output logic [mlptw_pkg::PPN_W-1:0]         o_ppn_out,
    output logic                                o_out_of_frames,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mlptw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mlptw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mlptw_pkg::t_cmd    cmd;
    mlptw_pkg::t_status status;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    mlptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mlptw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_action        (i_action),
        .i_vpn           (i_vpn),
        .i_ppn           (i_ppn),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mapped        (o_mapped),
        .o_ppn_out       (o_ppn_out),
        .o_out_of_frames (o_out_of_frames)
    );

endmodule
